// ===== src/mdoq_pkg.sv =====
// ----------------------------------------------------------------------------
// mdoq_pkg
// shared types and constants of the multicast drop-oldest queue block
// ----------------------------------------------------------------------------
package mdoq_pkg;

	localparam int DEFAULT_DEPTH = 4;
	localparam int NUM_TOPICS    = 6;
	localparam int CFG_SLOTS     = 4;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic ACT_PUBLISH = 1'b0;
	localparam logic ACT_FETCH   = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_TOPIC_MAP = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_MAP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_FETCH,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic        action;
		logic [2:0]  topic;
		logic [1:0]  subscriber;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		logic [2:0]  push_hits;
		logic        fetched;
		logic [63:0] fetched_data;
		logic [3:0]  pending_count;
		logic [31:0] drop_tally;
	} rsp_t;

endpackage

// ===== src/mdoq_store.sv =====
// ----------------------------------------------------------------------------
// mdoq_store
// message ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module mdoq_store #(
	parameter int AW = 5,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/multicast_drop_oldest_queues_core.sv =====
// ----------------------------------------------------------------------------
// multicast_drop_oldest_queues_core
// publish/subscribe queues, one ring per subscriber, dropping the oldest entry
// when a publish finds the ring full
//
//   channel   handshake            payload
//   request   req_valid/req_stall  req  (mdoq_pkg::req_t)
//   result    rsp_valid/rsp_stall  rsp  (mdoq_pkg::rsp_t)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a publish walks the subscribers one per cycle through a single update unit,
// then the result is loaded from the report state
// a fetch does the pointer update with the ram read, then the result load
// the ram has a single read port, which sets the fetch latency
// req_stall is high from acceptance until the result enters the output register
// a result stalled at the output does not hold back the next request
// reset clears pointers, fill levels, drop counters and the config registers
// ----------------------------------------------------------------------------
module multicast_drop_oldest_queues_core #(
	parameter int NUM_SUBSCRIBERS = 4,
	parameter int MAX_DEPTH       = 8,
	parameter int MESSAGE_BITS    = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  mdoq_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output mdoq_pkg::rsp_t                       rsp,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mdoq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mdoq_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int SW   = (NUM_SUBSCRIBERS > 1) ? $clog2(NUM_SUBSCRIBERS) : 1;
	localparam int PW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int FW   = $clog2(MAX_DEPTH + 1);
	localparam int SUMW = ((PW > FW) ? PW : FW) + 1;
	localparam int DEF_EFF = (mdoq_pkg::DEFAULT_DEPTH > MAX_DEPTH) ?
		MAX_DEPTH : mdoq_pkg::DEFAULT_DEPTH;

	mdoq_pkg::state_t state_q, state_d;

	logic [mdoq_pkg::CFG_DATA_BITS-1:0] topic_map_q;
	logic [mdoq_pkg::CFG_DATA_BITS-1:0] depth_map_q;

	logic [PW-1:0] rp_q   [NUM_SUBSCRIBERS];
	logic [FW-1:0] fill_q [NUM_SUBSCRIBERS];
	logic [31:0]   drop_q [NUM_SUBSCRIBERS];

	logic                    act_q;
	logic [2:0]              topic_q;
	logic [1:0]              sel_q;
	logic [MESSAGE_BITS-1:0] payload_q;
	logic [SW-1:0]           idx_q;
	logic [2:0]              cnt_q;
	logic                    got_q;
	logic                    rsp_valid_q;
	mdoq_pkg::rsp_t          rsp_q;

	logic                    req_acc;
	logic                    sel_ok;
	logic [SW-1:0]           sel_idx;
	logic [SW-1:0]           rd_idx;
	logic                    in_reg;
	logic [3:0]              nib_t;
	logic [3:0]              nib_d;
	logic [FW-1:0]           eff_d;
	logic                    match;
	logic [PW-1:0]           cur_rp;
	logic [FW-1:0]           cur_fill;
	logic [31:0]             cur_drop;
	logic [PW-1:0]           rp_inc;
	logic [SUMW-1:0]         sum;
	logic [PW-1:0]           wslot;
	logic                    depth_one;
	logic                    drop_old;
	logic                    push_we;
	logic                    fetch_pop;
	logic                    rsp_load;
	logic                    last_idx;
	logic [MESSAGE_BITS-1:0] rdata;

	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign sel_ok    = int'(sel_q) < NUM_SUBSCRIBERS;
	assign sel_idx   = SW'(sel_q);
	assign last_idx  = idx_q == SW'(NUM_SUBSCRIBERS - 1);
	assign rd_idx    = (state_q == mdoq_pkg::ST_PUSH) ? idx_q : sel_idx;

	// shared update unit
	assign cur_rp   = rp_q[rd_idx];
	assign cur_fill = fill_q[rd_idx];
	assign cur_drop = drop_q[rd_idx];
	assign in_reg   = int'(rd_idx) < mdoq_pkg::CFG_SLOTS;
	assign nib_t    = 4'(topic_map_q >> {rd_idx, 2'b00});
	assign nib_d    = 4'(depth_map_q >> {rd_idx, 2'b00});

	always_comb begin
		if (nib_d == 4'd0) begin
			eff_d = FW'(DEF_EFF);
		end else if (int'(nib_d) > MAX_DEPTH) begin
			eff_d = FW'(MAX_DEPTH);
		end else begin
			eff_d = FW'(nib_d);
		end
	end

	assign match = in_reg && nib_t[3] && (nib_t[2:0] == topic_q)
		&& (int'(topic_q) < mdoq_pkg::NUM_TOPICS);
	assign depth_one = eff_d == FW'(1);
	assign drop_old  = !depth_one && (cur_fill >= eff_d);
	assign rp_inc    = (cur_rp == PW'(MAX_DEPTH - 1)) ? '0 : cur_rp + PW'(1);
	assign sum       = SUMW'(cur_rp) + SUMW'(cur_fill);

	always_comb begin
		if (depth_one) begin
			wslot = cur_rp;
		end else if (sum >= SUMW'(MAX_DEPTH)) begin
			wslot = PW'(sum - SUMW'(MAX_DEPTH));
		end else begin
			wslot = PW'(sum);
		end
	end

	// sequencer, next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mdoq_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_d = (req.action == mdoq_pkg::ACT_FETCH) ?
						mdoq_pkg::ST_FETCH : mdoq_pkg::ST_PUSH;
				end
			end
			mdoq_pkg::ST_PUSH: begin
				if (last_idx) begin
					state_d = mdoq_pkg::ST_REPORT;
				end
			end
			mdoq_pkg::ST_FETCH: begin
				state_d = mdoq_pkg::ST_REPORT;
			end
			mdoq_pkg::ST_REPORT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = mdoq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdoq_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer, outputs
	always_comb begin
		req_stall = 1'b1;
		push_we   = 1'b0;
		fetch_pop = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			mdoq_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			mdoq_pkg::ST_PUSH: begin
				push_we = match;
			end
			mdoq_pkg::ST_FETCH: begin
				fetch_pop = sel_ok && (cur_fill != '0);
			end
			mdoq_pkg::ST_REPORT: begin
				rsp_load = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdoq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topic_map_q <= '0;
			depth_map_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mdoq_pkg::REG_TOPIC_MAP: topic_map_q <= cfg_data;
				mdoq_pkg::REG_DEPTH_MAP: depth_map_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SUBSCRIBERS; i++) begin
				rp_q[i]   <= '0;
				fill_q[i] <= '0;
				drop_q[i] <= '0;
			end
		end else if (push_we) begin
			if (depth_one) begin
				fill_q[rd_idx] <= FW'(1);
			end else if (drop_old) begin
				rp_q[rd_idx]   <= rp_inc;
				drop_q[rd_idx] <= cur_drop + 32'd1;
			end else begin
				fill_q[rd_idx] <= cur_fill + FW'(1);
			end
		end else if (fetch_pop) begin
			rp_q[rd_idx]   <= rp_inc;
			fill_q[rd_idx] <= cur_fill - FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			cnt_q   <= '0;
			got_q   <= 1'b0;
			act_q   <= mdoq_pkg::ACT_PUBLISH;
			topic_q <= '0;
			sel_q   <= '0;
		end else if (req_acc) begin
			idx_q   <= '0;
			cnt_q   <= '0;
			got_q   <= 1'b0;
			act_q   <= req.action;
			topic_q <= req.topic;
			sel_q   <= req.subscriber;
		end else begin
			if (state_q == mdoq_pkg::ST_PUSH) begin
				idx_q <= idx_q + SW'(1);
			end
			if (push_we) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (fetch_pop) begin
				got_q <= 1'b1;
			end
		end
	end

	// request fields, payload only
	always_ff @(posedge clk) begin
		if (req_acc) begin
			payload_q <= MESSAGE_BITS'(req.payload);
		end
	end

	mdoq_store #(
		.AW(SW + PW),
		.DW(MESSAGE_BITS)
	) u_store (
		.clk   (clk),
		.we    (push_we),
		.waddr ({rd_idx, wslot}),
		.wdata (payload_q),
		.re    (fetch_pop),
		.raddr ({rd_idx, cur_rp}),
		.rdata (rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.push_hits     <= (act_q == mdoq_pkg::ACT_PUBLISH) ? cnt_q : 3'd0;
			rsp_q.fetched       <= got_q;
			rsp_q.fetched_data  <= got_q ? 64'(rdata) : 64'd0;
			rsp_q.pending_count <= sel_ok ? 4'(cur_fill) : 4'd0;
			rsp_q.drop_tally    <= sel_ok ? cur_drop : 32'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_fill <= FW'(MAX_DEPTH))
		else $error("fill level above ring size");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_pop |-> (sel_ok && cur_fill != '0))
		else $error("pop from empty ring");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_pop |=> (fill_q[sel_idx] == $past(cur_fill) - FW'(1)))
		else $error("pop did not lower fill level");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("second request taken while busy");

	a_fetch_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.fetched) |-> (rsp.fetched_data == 64'd0))
		else $error("data shown without a pop");

endmodule

// ===== tb/sv/tb_multicast_drop_oldest_queues_core.sv =====
// ----------------------------------------------------------------------------
// tb_multicast_drop_oldest_queues_core
// self-checking bench for the multicast drop-oldest queue block: a directed
// pass over overwrite, drop, lowered depth and unused topics, then random
// publish/fetch traffic under several idle and stall mixes, and one long
// result hold-off that fills the block; every result is checked field by
// field against an in-bench model of the subscriber rings
// ----------------------------------------------------------------------------
module tb_multicast_drop_oldest_queues_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SUBS       = 4;
	localparam int MAX_DEPTH      = 8;
	localparam int MSG_BITS       = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	mdoq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	mdoq_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mdoq_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [mdoq_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	// subscriber ring model
	logic [63:0] ring_word [NUM_SUBS][MAX_DEPTH];
	logic [2:0] ring_head [NUM_SUBS];
	logic [3:0] ring_fill [NUM_SUBS];
	logic [31:0] drop_total [NUM_SUBS];
	logic [15:0] topic_map_q = '0;
	logic [15:0] depth_map_q = '0;

	mdoq_pkg::rsp_t awaited_rsp [$];
	int error_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_start = 1'b0;

	multicast_drop_oldest_queues_core #(
		.NUM_SUBSCRIBERS(NUM_SUBS),
		.MAX_DEPTH(MAX_DEPTH),
		.MESSAGE_BITS(MSG_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned ring_depth(int unsigned s);
		logic [3:0] d;
		d = depth_map_q[4*s +: 4];
		if (d == 4'd0)
			return (mdoq_pkg::DEFAULT_DEPTH > MAX_DEPTH) ? MAX_DEPTH :
				mdoq_pkg::DEFAULT_DEPTH;
		if (d > MAX_DEPTH)
			return MAX_DEPTH;
		return 32'(d);
	endfunction

	function automatic void ring_push(int unsigned s, logic [63:0] w);
		int unsigned d;
		d = ring_depth(s);
		if (d == 1) begin
			ring_word[s][ring_head[s]] = w;
			ring_fill[s] = 4'd1;
			return;
		end
		if (ring_fill[s] >= d) begin
			ring_head[s] = ring_head[s] + 3'd1;
			ring_fill[s] = ring_fill[s] - 4'd1;
			drop_total[s] = drop_total[s] + 32'd1;
		end
		ring_word[s][(int'(ring_head[s]) + int'(ring_fill[s])) % MAX_DEPTH] = w;
		ring_fill[s] = ring_fill[s] + 4'd1;
	endfunction

	function automatic mdoq_pkg::rsp_t queue_outcome(mdoq_pkg::req_t r);
		mdoq_pkg::rsp_t o;
		logic [3:0] nib;
		int s;
		o = '0;
		if (r.action == mdoq_pkg::ACT_PUBLISH) begin
			if (r.topic < mdoq_pkg::NUM_TOPICS) begin
				for (s = 0; s < NUM_SUBS; s++) begin
					nib = topic_map_q[4*s +: 4];
					if (nib[3] && nib[2:0] == r.topic) begin
						ring_push(s, r.payload);
						o.push_hits = o.push_hits + 3'd1;
					end
				end
			end
		end else if (ring_fill[r.subscriber] != 4'd0) begin
			o.fetched = 1'b1;
			o.fetched_data = ring_word[r.subscriber][ring_head[r.subscriber]];
			ring_head[r.subscriber] = ring_head[r.subscriber] + 3'd1;
			ring_fill[r.subscriber] = ring_fill[r.subscriber] - 4'd1;
		end
		o.pending_count = ring_fill[r.subscriber];
		o.drop_tally = drop_total[r.subscriber];
		return o;
	endfunction

	function automatic void report_field(string field, logic [63:0] want, logic [63:0] got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch %s: expected %0h, got %0h", field, want, got);
	endfunction

	function automatic void compare_result(mdoq_pkg::rsp_t want, mdoq_pkg::rsp_t got);
		if (got.push_hits !== want.push_hits)
			report_field("push_hits", 64'(want.push_hits), 64'(got.push_hits));
		if (got.fetched !== want.fetched)
			report_field("fetched", 64'(want.fetched), 64'(got.fetched));
		if (got.fetched_data !== want.fetched_data)
			report_field("fetched_data", want.fetched_data, got.fetched_data);
		if (got.pending_count !== want.pending_count)
			report_field("pending_count", 64'(want.pending_count),
				64'(got.pending_count));
		if (got.drop_tally !== want.drop_tally)
			report_field("drop_tally", 64'(want.drop_tally), 64'(got.drop_tally));
	endfunction

	// request capture and result check
	always @(posedge clk) begin
		if (arst_n && req_valid === 1'b1 && req_stall === 1'b0)
			awaited_rsp.push_back(queue_outcome(req));
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (awaited_rsp.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("result with no request waiting: %p", rsp);
			end else begin
				compare_result(awaited_rsp.pop_front(), rsp);
			end
		end
	end

	// result stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) ||
			(rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
			(cfg_valid === 1'b1 && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic mdoq_pkg::req_t make_req(logic act, logic [2:0] topic,
		logic [1:0] sub, logic [63:0] payload);
		mdoq_pkg::req_t r;
		r.action = act;
		r.topic = topic;
		r.subscriber = sub;
		r.payload = payload;
		return r;
	endfunction

	function automatic mdoq_pkg::req_t random_request();
		mdoq_pkg::req_t r;
		int unsigned pick;
		logic [3:0] nib;
		pick = $urandom_range(NUM_SUBS - 1);
		nib = topic_map_q[4*pick +: 4];
		r.action = ($urandom_range(99) < 55) ? mdoq_pkg::ACT_PUBLISH : mdoq_pkg::ACT_FETCH;
		r.subscriber = 2'($urandom_range(3));
		r.topic = ($urandom_range(3) != 0) ? nib[2:0] : 3'($urandom_range(7));
		case ($urandom_range(15))
			0: r.payload = '0;
			1: r.payload = '1;
			default: r.payload = {$urandom, $urandom};
		endcase
		return r;
	endfunction

	function automatic logic [15:0] random_topic_map();
		logic [15:0] m;
		int s;
		for (s = 0; s < NUM_SUBS; s++) begin
			m[4*s + 3] = ($urandom_range(3) != 0);
			m[4*s +: 3] = ($urandom_range(7) != 0) ? 3'($urandom_range(5)) : 3'($urandom_range(7));
		end
		return m;
	endfunction

	task automatic offer_request(input mdoq_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	task automatic settle_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (NUM_SUBS + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mdoq_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [15:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == mdoq_pkg::REG_TOPIC_MAP)
			topic_map_q = value;
		else
			depth_map_q = value;
	endtask

	task automatic set_config(input logic [15:0] topics, input logic [15:0] depths);
		settle_idle();
		write_reg(mdoq_pkg::REG_TOPIC_MAP, topics);
		write_reg(mdoq_pkg::REG_DEPTH_MAP, depths);
		cfg_valid <= 1'b0;
	endtask

	// overwrite at depth one, default depth with drops, unused topics, disabled slot
	task automatic test_directed();
		int i;
		send_idle_pct = 0;
		stall_pct = 0;
		set_config(16'h1D88, 16'h2F01);
		offer_request(make_req(mdoq_pkg::ACT_FETCH, 3'd0, 2'd0, '1));
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd0, 2'd0, '0));
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd0, 2'd1, '1));
		offer_request(make_req(mdoq_pkg::ACT_FETCH, 3'd0, 2'd0, '0));
		for (i = 0; i < 4; i++)
			offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd0, 2'd1,
				{$urandom, $urandom}));
		offer_request(make_req(mdoq_pkg::ACT_FETCH, 3'd0, 2'd1, '0));
		offer_request(make_req(mdoq_pkg::ACT_FETCH, 3'd7, 2'd1, '0));
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd5, 2'd2, 64'h8000_0000_0000_0001));
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd5, 2'd2, 64'h7fff_ffff_ffff_fffe));
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd6, 2'd2, '1));
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd7, 2'd3, '1));
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd1, 2'd3, '1));
		offer_request(make_req(mdoq_pkg::ACT_FETCH, 3'd0, 2'd3, '0));
	endtask

	// entries stay when the depth is lowered under them
	task automatic test_depth_lowered();
		int i;
		set_config(16'h0008, 16'h0008);
		for (i = 0; i < 4; i++)
			offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd0, 2'd0,
				{$urandom, $urandom}));
		set_config(16'h0008, 16'h0002);
		offer_request(make_req(mdoq_pkg::ACT_PUBLISH, 3'd0, 2'd0, {$urandom, $urandom}));
		for (i = 0; i < 5; i++)
			offer_request(make_req(mdoq_pkg::ACT_FETCH, 3'd0, 2'd0, '0));
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_mix,
		input logic [15:0] edge_topics, input logic [15:0] edge_depths);
		int i;
		set_config(random_topic_map(), 16'($urandom));
		send_idle_pct = idle_pct;
		stall_pct = stall_mix;
		for (i = 0; i < 90; i++)
			offer_request(random_request());
		set_config(edge_topics, edge_depths);
		for (i = 0; i < 90; i++)
			offer_request(random_request());
	endtask

	// long result hold-off while requests keep coming
	task automatic test_backpressure();
		int i;
		set_config(16'h8888, 16'h0000);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_start = 1'b1;
		for (i = 0; i < 40; i++)
			offer_request(random_request());
	endtask

	initial begin
		int s;
		for (s = 0; s < NUM_SUBS; s++) begin
			ring_head[s] = '0;
			ring_fill[s] = '0;
			drop_total[s] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_depth_lowered();
		test_random_phase(0, 0, 16'hFFFF, 16'hFFFF);
		test_random_phase(68, 0, 16'h0000, 16'h0000);
		test_random_phase(0, 68, 16'h8888, 16'h1111);
		test_random_phase(10, 10, 16'hDDDD, 16'hFFFF);
		test_backpressure();
		settle_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0 && awaited_rsp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== multicast_drop_oldest_queues_core.f =====
src/mdoq_pkg.sv
src/mdoq_store.sv
src/multicast_drop_oldest_queues_core.sv
tb/sv/tb_multicast_drop_oldest_queues_core.sv
